[hw/rtl/dbx_pkg.sv]
package dbx_pkg;

    localparam int MAX_CHARS   = 22;
    localparam int NUM_LANES   = 8;
    localparam int WT_ENTRIES  = 184;
    localparam int RECIP_SHIFT = 23;

    localparam logic [7:0]  MOD_P = 8'd211;
    // floor(2^23 / 211); quotient comes out exact or one low for a 15-bit portion
    localparam logic [15:0] RECIP = 16'd39756;
    localparam logic [4:0]  MIN_COUNT = 5'd4;
    localparam logic [4:0]  MAX_COUNT = 5'd31;
    localparam logic [5:0]  OSUM_MIN = 6'd4;
    localparam logic [5:0]  OSUM_MAX = 6'd13;
    localparam logic [2:0]  FINDER_MAX = 3'd5;

    // 23 rows x 8 columns, row-major
    localparam logic [7:0] WTAB [0:WT_ENTRIES-1] = '{
        8'd1,   8'd3,   8'd9,   8'd27,  8'd81,  8'd32,  8'd96,  8'd77,
        8'd20,  8'd60,  8'd180, 8'd118, 8'd143, 8'd7,   8'd21,  8'd63,
        8'd189, 8'd145, 8'd13,  8'd39,  8'd117, 8'd140, 8'd209, 8'd205,
        8'd193, 8'd157, 8'd49,  8'd147, 8'd19,  8'd57,  8'd171, 8'd91,
        8'd62,  8'd186, 8'd136, 8'd197, 8'd169, 8'd85,  8'd44,  8'd132,
        8'd185, 8'd133, 8'd188, 8'd142, 8'd4,   8'd12,  8'd36,  8'd108,
        8'd113, 8'd128, 8'd173, 8'd97,  8'd80,  8'd29,  8'd87,  8'd50,
        8'd150, 8'd28,  8'd84,  8'd41,  8'd123, 8'd158, 8'd52,  8'd156,
        8'd46,  8'd138, 8'd203, 8'd187, 8'd139, 8'd206, 8'd196, 8'd166,
        8'd76,  8'd17,  8'd51,  8'd153, 8'd37,  8'd111, 8'd122, 8'd155,
        8'd43,  8'd129, 8'd176, 8'd106, 8'd107, 8'd110, 8'd119, 8'd146,
        8'd16,  8'd48,  8'd144, 8'd10,  8'd30,  8'd90,  8'd59,  8'd177,
        8'd109, 8'd116, 8'd137, 8'd200, 8'd178, 8'd112, 8'd125, 8'd164,
        8'd70,  8'd210, 8'd208, 8'd202, 8'd184, 8'd130, 8'd179, 8'd115,
        8'd134, 8'd191, 8'd151, 8'd31,  8'd93,  8'd68,  8'd204, 8'd190,
        8'd148, 8'd22,  8'd66,  8'd198, 8'd172, 8'd94,  8'd71,  8'd2,
        8'd6,   8'd18,  8'd54,  8'd162, 8'd64,  8'd192, 8'd154, 8'd40,
        8'd120, 8'd149, 8'd25,  8'd75,  8'd14,  8'd42,  8'd126, 8'd167,
        8'd79,  8'd26,  8'd78,  8'd23,  8'd69,  8'd207, 8'd199, 8'd175,
        8'd103, 8'd98,  8'd83,  8'd38,  8'd114, 8'd131, 8'd182, 8'd124,
        8'd161, 8'd61,  8'd183, 8'd127, 8'd170, 8'd88,  8'd53,  8'd159,
        8'd55,  8'd165, 8'd73,  8'd8,   8'd24,  8'd72,  8'd5,   8'd15,
        8'd45,  8'd135, 8'd194, 8'd160, 8'd58,  8'd174, 8'd100, 8'd89
    };

    typedef struct packed {
        logic        is_check;
        logic        last;
        logic        ok;
        logic        fbad;
        logic [11:0] value;
    } dbx_ctl_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } dbx_adv_t;

    function automatic logic [7:0] dbx_weight(input logic [4:0] row, input logic [2:0] col);
        logic [7:0] idx;
        idx = {row, col};
        if (idx < 8'(WT_ENTRIES))
            return WTAB[idx];
        else
            return 8'd0;
    endfunction

endpackage

[hw/rtl/dbx_lane.sv]
module dbx_lane (
    input  logic        clk,
    input  logic        en,
    input  logic        zero,
    input  logic [4:0]  row,
    input  logic [2:0]  col,
    input  logic [3:0]  wid,
    output logic [11:0] prod
);
    import dbx_pkg::*;

    logic [11:0] prod_reg;
    logic [11:0] prod_next;
    logic [7:0]  wt;

    assign wt        = dbx_weight(row, col);
    assign prod_next = zero ? 12'd0 : 12'(wid) * 12'(wt);

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[hw/rtl/dbx_merge.sv]
module dbx_merge (
    input  logic                  clk,
    input  dbx_pkg::dbx_adv_t     adv,
    input  logic [11:0]           prod [dbx_pkg::NUM_LANES],
    output logic [14:0]           portion,
    output logic [7:0]            pmod
);
    import dbx_pkg::*;

    logic [14:0] sum_reg;
    logic [14:0] sum_next;
    logic [14:0] por3_reg;
    logic [6:0]  q_reg;
    logic [6:0]  q_next;
    logic [30:0] qprod;
    logic [14:0] por4_reg;
    logic [7:0]  pmod_reg;
    logic [7:0]  pmod_next;
    logic [14:0] qm;
    logic [14:0] rem;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_LANES; i++)
            sum_next = sum_next + 15'(prod[i]);
    end

    // quotient by 211 through the reciprocal, remainder fixed up below
    assign qprod  = 31'(sum_reg) * 31'(RECIP);
    assign q_next = qprod[RECIP_SHIFT+6:RECIP_SHIFT];

    assign qm  = 15'(q_reg) * 15'(MOD_P);
    assign rem = por3_reg - qm;

    always_comb
    begin
        if (rem >= 15'(MOD_P))
            pmod_next = 8'(rem - 15'(MOD_P));
        else
            pmod_next = rem[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
            sum_reg <= sum_next;
        if (adv.s3)
        begin
            por3_reg <= sum_reg;
            q_reg    <= q_next;
        end
        if (adv.s4)
        begin
            por4_reg <= por3_reg;
            pmod_reg <= pmod_next;
        end
    end

    assign portion = por4_reg;
    assign pmod    = pmod_reg;

endmodule

[hw/rtl/dbx_acc.sv]
module dbx_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              upd,
    input  dbx_pkg::dbx_ctl_t ctl,
    input  logic [14:0]       portion,
    input  logic [7:0]        pmod,
    output logic              char_ok,
    output logic [14:0]       portion_out,
    output logic              symbol_done,
    output logic              checksum_ok
);
    import dbx_pkg::*;

    logic [7:0]  sum_reg,    sum_next;
    logic [4:0]  count_reg,  count_next;
    logic [11:0] target_reg, target_next;
    logic        bad_reg,    bad_next;
    logic [12:0] off_reg,    off_next;

    logic [7:0]  sum_n;
    logic [4:0]  count_n;
    logic [11:0] target_n;
    logic        bad_n;
    logic [12:0] off_n;
    logic [8:0]  cand;
    logic        match;

    logic        ok_reg;
    logic [14:0] por_reg;
    logic        done_reg;
    logic        match_reg;

    assign cand = {1'b0, sum_reg} + {1'b0, pmod};

    always_comb
    begin
        if (ctl.is_check)
        begin
            sum_n    = '0;
            count_n  = 5'd1;
            target_n = ctl.value;
            bad_n    = !ctl.ok || ctl.fbad;
            off_n    = '0;
        end
        else
        begin
            sum_n    = (cand >= 9'(MOD_P)) ? 8'(cand - 9'(MOD_P)) : cand[7:0];
            count_n  = (count_reg < MAX_COUNT) ? count_reg + 5'd1 : count_reg;
            target_n = target_reg;
            bad_n    = bad_reg || (count_reg == 5'd0) || !ctl.ok || ctl.fbad
                       || (count_n > 5'(MAX_CHARS));
            // off tracks 211*(count-4) once count reaches 4
            off_n    = (count_n > MIN_COUNT && count_n != count_reg)
                       ? off_reg + 13'(MOD_P) : off_reg;
        end
        match = ctl.last && !bad_n && (count_n >= MIN_COUNT)
                && ((off_n + 13'(sum_n)) == 13'(target_n));
    end

    always_comb
    begin
        sum_next    = sum_reg;
        count_next  = count_reg;
        target_next = target_reg;
        bad_next    = bad_reg;
        off_next    = off_reg;
        if (upd)
        begin
            if (ctl.last)
            begin
                sum_next    = '0;
                count_next  = '0;
                target_next = '0;
                bad_next    = 1'b0;
                off_next    = '0;
            end
            else
            begin
                sum_next    = sum_n;
                count_next  = count_n;
                target_next = target_n;
                bad_next    = bad_n;
                off_next    = off_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            count_reg  <= '0;
            target_reg <= '0;
            bad_reg    <= 1'b0;
            off_reg    <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            target_reg <= target_next;
            bad_reg    <= bad_next;
            off_reg    <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok_reg    <= ctl.ok;
            por_reg   <= portion;
            done_reg  <= ctl.last;
            match_reg <= match;
        end
    end

    assign char_ok     = ok_reg;
    assign portion_out = por_reg;
    assign symbol_done = done_reg;
    assign checksum_ok = match_reg;

endmodule

[hw/rtl/databar_expanded_check_verify.sv]
// channel   dir  beat fields
// s_axis    in   tdata: finder_value, odd_pattern, left_char, odd_widths, even_widths,
//                char_value; tuser: is_check_char; tlast: last_char
// m_axis    out  tdata: char_ok, portion, checksum_ok; tlast: symbol_done
//
// One beat per cycle sustained while m_axis_tready is high.
// Stages: 8 weight lanes, lane sum, reciprocal quotient, mod-211 remainder,
// accumulate into the output register.
// Each stage holds while the one after it is full and stalled; s_axis_tready
// falls only when all five stages are full and m_axis_tready is low.
// Reset clears the stage valids and the running symbol state.
module databar_expanded_check_verify (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] finder_value, [3] odd_pattern, [4] left_char, [20:5] odd_widths,
    // [36:21] even_widths, [48:37] char_value, [55:49] zero
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // [0] is_check_char
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] char_ok, [15:1] portion, [16] checksum_ok, [23:17] zero
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import dbx_pkg::*;

    logic [2:0]  finder;
    logic        oddp;
    logic        left;
    logic [15:0] ow;
    logic [15:0] ew;
    logic [5:0]  osum;
    logic        a1left;
    logic        zero;
    logic [4:0]  row;
    logic [3:0]  wid [NUM_LANES];
    logic [11:0] prod [NUM_LANES];
    dbx_ctl_t    ctl_in;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic adv1, adv2, adv3, adv4, adv5;
    dbx_adv_t adv;
    dbx_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;

    logic [14:0] portion4;
    logic [7:0]  pmod4;
    logic        char_ok;
    logic [14:0] portion;
    logic        symbol_done;
    logic        checksum_ok;

    assign finder = s_axis_tdata[2:0];
    assign oddp   = s_axis_tdata[3];
    assign left   = s_axis_tdata[4];
    assign ow     = s_axis_tdata[20:5];
    assign ew     = s_axis_tdata[36:21];

    assign osum = 6'(ow[3:0]) + 6'(ow[7:4]) + 6'(ow[11:8]) + 6'(ow[15:12]);

    assign ctl_in.is_check = s_axis_tuser;
    assign ctl_in.last     = s_axis_tlast;
    assign ctl_in.ok       = !osum[0] && osum >= OSUM_MIN && osum <= OSUM_MAX;
    assign ctl_in.fbad     = finder > FINDER_MAX;
    assign ctl_in.value    = s_axis_tdata[48:37];

    assign a1left = (finder == 3'd0) && oddp && left;
    assign zero   = s_axis_tuser || ctl_in.fbad || a1left;
    assign row    = zero ? 5'd0
                  : {finder, 2'b00} + {3'b000, !oddp, 1'b0} + 5'(!left) - 5'd1;

    // odd element i on column 2i, even element i on column 2i+1
    always_comb
    begin
        for (int i = 0; i < NUM_LANES / 2; i++)
        begin
            wid[2*i]   = ow[4*i +: 4];
            wid[2*i+1] = ew[4*i +: 4];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            dbx_lane u_lane (
                .clk  (clk),
                .en   (adv1),
                .zero (zero),
                .row  (row),
                .col  (3'(g)),
                .wid  (wid[g]),
                .prod (prod[g])
            );
        end
    endgenerate

    assign adv5 = !v5_reg || m_axis_tready;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign adv.s2 = adv2;
    assign adv.s3 = adv3;
    assign adv.s4 = adv4;

    assign v1_next = adv1 ? s_axis_tvalid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;
    assign v4_next = adv4 ? v3_reg : v4_reg;
    assign v5_next = adv5 ? v4_reg : v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            ctl1_reg <= ctl_in;
        if (adv2)
            ctl2_reg <= ctl1_reg;
        if (adv3)
            ctl3_reg <= ctl2_reg;
        if (adv4)
            ctl4_reg <= ctl3_reg;
    end

    dbx_merge u_merge (
        .clk     (clk),
        .adv     (adv),
        .prod    (prod),
        .portion (portion4),
        .pmod    (pmod4)
    );

    dbx_acc u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv5),
        .upd         (adv5 && v4_reg),
        .ctl         (ctl4_reg),
        .portion     (portion4),
        .pmod        (pmod4),
        .char_ok     (char_ok),
        .portion_out (portion),
        .symbol_done (symbol_done),
        .checksum_ok (checksum_ok)
    );

    assign s_axis_tready = adv1;
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {7'b0, checksum_ok, portion, char_ok};
    assign m_axis_tlast  = symbol_done;

endmodule

[hw/rtl/dbx_chk.sv]
module dbx_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // checksum flag only on the closing beat
    a_ck_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[16])
        else $error("checksum_ok without symbol_done");

    // a good symbol cannot end on a bad character
    a_ck_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[0])
        else $error("checksum_ok on an invalid character");

    // weighted portion bounded by 8 * 15 * 210
    a_por: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:1] <= 15'd25200)
        else $error("portion out of range");

endmodule

bind databar_expanded_check_verify dbx_chk u_dbx_chk (.*);
